[hdl/spq_pkg.sv]
// shared types and constants for the sorted priority queue
package spq_pkg;

    localparam int CAPACITY_DEFAULT   = 16;
    localparam int VALUE_BITS_DEFAULT = 32;

    localparam int OP_W       = 2;
    localparam int TAG_W      = 32;
    localparam int PRIO_W     = 32;
    localparam int COUNT_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_CLR = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    // one-hot controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } state_t;

    // commands from controller to datapath, valid for the accept cycle
    typedef struct packed {
        logic load;
        logic enq;
        logic deq;
        logic clr;
        logic drop;
    } cmd_t;

    // datapath status seen by the controller
    typedef struct packed {
        logic full;
        logic empty;
    } status_t;

endpackage

[hdl/spq_ctrl.sv]
// controller: handshake state machine and op decode
module spq_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [spq_pkg::OP_W-1:0]    s_op,
    output logic                        m_valid,
    input  logic                        m_ready,
    input  spq_pkg::status_t            status,
    output spq_pkg::cmd_t               cmd
);
    import spq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    op_t    op;

    assign op      = op_t'(s_op);
    assign m_valid = (state_reg == ST_HOLD);
    assign s_ready = (state_reg == ST_IDLE) || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (accept) state_next = ST_HOLD;
                else if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        cmd = '0;
        cmd.load = accept;
        if (accept) begin
            unique case (op)
                OP_ENQ: begin
                    cmd.enq  = !status.full;
                    cmd.drop = status.full;
                end
                OP_DEQ: cmd.deq = !status.empty;
                OP_CLR: cmd.clr = 1'b1;
                OP_NOP: ;
                default: ;
            endcase
        end
    end

endmodule

[hdl/spq_datapath.sv]
// datapath: sorted row of entry cells, count and result registers
module spq_datapath #(
    parameter int CAPACITY   = spq_pkg::CAPACITY_DEFAULT,
    parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  spq_pkg::cmd_t                       cmd,
    output spq_pkg::status_t                    status,
    input  logic [spq_pkg::TAG_W-1:0]           s_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   s_priority_req,
    output logic [spq_pkg::TAG_W-1:0]           m_taken_value,
    output logic                                m_taken_valid,
    output logic [spq_pkg::TAG_W-1:0]           m_head_value,
    output logic signed [spq_pkg::PRIO_W-1:0]   m_head_priority,
    output logic [spq_pkg::COUNT_W-1:0]         m_count,
    output logic                                m_empty_res,
    output logic                                m_dropped
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [VALUE_BITS-1:0]   val_reg  [CAPACITY];
    logic [VALUE_BITS-1:0]   val_next [CAPACITY];
    logic signed [PRIO_W-1:0] prio_reg  [CAPACITY];
    logic signed [PRIO_W-1:0] prio_next [CAPACITY];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CAPACITY-1:0]     shift;

    logic [VALUE_BITS-1:0]   taken_reg;
    logic                    taken_valid_reg;
    logic                    dropped_reg;

    logic [VALUE_BITS+TAG_W-1:0] in_ext;
    logic [VALUE_BITS-1:0]       in_val;
    logic [TAG_W+VALUE_BITS-1:0] taken_ext;
    logic [TAG_W+VALUE_BITS-1:0] head_ext;
    logic [CNT_W+COUNT_W-1:0]    count_ext;

    assign in_ext = {{VALUE_BITS{1'b0}}, s_value};
    assign in_val = in_ext[VALUE_BITS-1:0];

    assign status.full  = (count_reg == CNT_W'(CAPACITY));
    assign status.empty = (count_reg == '0);

    // cells holding a priority above the new one move back by one
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            shift[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] > s_priority_req);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            val_next[i]  = val_reg[i];
            prio_next[i] = prio_reg[i];
            if (cmd.enq) begin
                if (i > 0 && shift[(i > 0) ? i - 1 : 0]) begin
                    val_next[i]  = val_reg[(i > 0) ? i - 1 : 0];
                    prio_next[i] = prio_reg[(i > 0) ? i - 1 : 0];
                end else if (shift[i] || CNT_W'(i) == count_reg) begin
                    val_next[i]  = in_val;
                    prio_next[i] = s_priority_req;
                end
            end else if (cmd.deq && i < CAPACITY - 1) begin
                val_next[i]  = val_reg[(i < CAPACITY - 1) ? i + 1 : i];
                prio_next[i] = prio_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.clr) count_next = '0;
        else if (cmd.enq) count_next = count_reg + 1'b1;
        else if (cmd.deq) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            val_reg[i]  <= val_next[i];
            prio_reg[i] <= prio_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) count_reg <= '0;
        else count_reg <= count_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            taken_reg       <= cmd.deq ? val_reg[0] : '0;
            taken_valid_reg <= cmd.deq;
            dropped_reg     <= cmd.drop;
        end
    end

    assign taken_ext = {{TAG_W{1'b0}}, taken_reg};
    assign head_ext  = {{TAG_W{1'b0}}, val_reg[0]};
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    assign m_taken_value   = taken_ext[TAG_W-1:0];
    assign m_taken_valid   = taken_valid_reg;
    assign m_dropped       = dropped_reg;
    assign m_head_value    = status.empty ? '0 : head_ext[TAG_W-1:0];
    assign m_head_priority = status.empty ? '0 : prio_reg[0];
    assign m_count         = count_ext[COUNT_W-1:0];
    assign m_empty_res     = status.empty;

endmodule

[hdl/sorted_priority_queue_top.sv]
// sorted priority queue top level: controller plus cell datapath
// result: registered, valid on the m_ side in the cycle after the item is accepted
// throughput: one item per cycle while the m_ side is ready or no result is held;
//   each op updates the whole cell row at once because every cell compares against the new priority in parallel
// reset: synchronous active-low aresetn empties the queue and drops any pending result
// entry cells are not cleared; only slots below the count are ever shown
module sorted_priority_queue_top #(
    parameter int CAPACITY   = spq_pkg::CAPACITY_DEFAULT,
    parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input item channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [spq_pkg::OP_W-1:0]            s_op,
    input  logic [spq_pkg::TAG_W-1:0]           s_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   s_priority_req,
    // result item channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [spq_pkg::TAG_W-1:0]           m_taken_value,
    output logic                                m_taken_valid,
    output logic [spq_pkg::TAG_W-1:0]           m_head_value,
    output logic signed [spq_pkg::PRIO_W-1:0]   m_head_priority,
    output logic [spq_pkg::COUNT_W-1:0]         m_count,
    output logic                                m_empty_res,
    output logic                                m_dropped
);
    import spq_pkg::*;

    // decoded per-item commands and queue status
    cmd_t    cmd;
    status_t status;

    // handshake and op decode; a new item is taken while the result
    // register is free or being drained in the same cycle
    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // sorted cell row: enqueue inserts behind equal priorities,
    // dequeue shifts every cell toward the head
    spq_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_value         (s_value),
        .s_priority_req  (s_priority_req),
        .m_taken_value   (m_taken_value),
        .m_taken_valid   (m_taken_valid),
        .m_head_value    (m_head_value),
        .m_head_priority (m_head_priority),
        .m_count         (m_count),
        .m_empty_res     (m_empty_res),
        .m_dropped       (m_dropped)
    );

endmodule

[sim/tb_top.sv]
// self-checking testbench for the sorted priority queue top level
`timescale 1ns / 100ps

module tb_top;
    import spq_pkg::*;

    localparam int DEPTH        = CAPACITY_DEFAULT;
    localparam int QUIET_LIMIT  = 2000;   // cycles with no handshake before giving up
    localparam int HOLD_CYCLES  = 300;    // long receiver stall, well past the pipe depth
    localparam int TAIL_CYCLES  = 10;     // quiet tail after the last results; leave a margin

    // one result item as the block should present it
    typedef struct {
        logic [TAG_W-1:0]   taken_value;
        logic               taken_valid;
        logic [TAG_W-1:0]   head_value;
        logic [PRIO_W-1:0]  head_priority;
        logic [COUNT_W-1:0] count;
        logic               empty_res;
        logic               dropped;
    } queue_result_t;

    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic [OP_W-1:0]           s_op           = OP_NOP;
    logic [TAG_W-1:0]          s_value        = '0;
    logic signed [PRIO_W-1:0]  s_priority_req = '0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic [TAG_W-1:0]          m_taken_value;
    logic                      m_taken_valid;
    logic [TAG_W-1:0]          m_head_value;
    logic signed [PRIO_W-1:0]  m_head_priority;
    logic [COUNT_W-1:0]        m_count;
    logic                      m_empty_res;
    logic                      m_dropped;

    // shadow copy of the queue contents, kept sorted like the hardware
    logic [TAG_W-1:0]          shadow_value [DEPTH];
    logic signed [PRIO_W-1:0]  shadow_prio  [DEPTH];
    int                        shadow_count;

    // results predicted at input accept, waiting for the m_ side
    queue_result_t             pending_results[$];

    // knobs the test tasks turn
    bit                        src_idle_on;
    bit                        sink_idle_on;
    int                        hold_request;

    // run statistics
    int                        items_sent;
    int                        results_seen;
    int                        drops_seen;
    int                        peak_depth;
    int                        mismatches;

    sorted_priority_queue_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_value         (s_value),
        .s_priority_req  (s_priority_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_taken_value   (m_taken_value),
        .m_taken_valid   (m_taken_valid),
        .m_head_value    (m_head_value),
        .m_head_priority (m_head_priority),
        .m_count         (m_count),
        .m_empty_res     (m_empty_res),
        .m_dropped       (m_dropped)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // -------------------------------------------------------------------------
    // predictor: apply one accepted item to the shadow queue and queue up the
    // result item it should produce
    // -------------------------------------------------------------------------
    task automatic predict_queue_op(input op_t op, input logic [TAG_W-1:0] val,
                                    input logic signed [PRIO_W-1:0] prio);
        queue_result_t res;
        int            slot;
        res = '{default: '0};
        case (op)
            OP_ENQ: begin
                if (shadow_count >= DEPTH) begin
                    // full: item refused, contents untouched
                    res.dropped = 1'b1;
                    drops_seen++;
                end else begin
                    // new entry goes behind every entry of equal priority
                    slot = shadow_count;
                    for (int i = 0; i < shadow_count; i++) begin
                        if (shadow_prio[i] > prio) begin
                            slot = i;
                            break;
                        end
                    end
                    for (int i = shadow_count; i > slot; i--) begin
                        shadow_value[i] = shadow_value[i-1];
                        shadow_prio[i]  = shadow_prio[i-1];
                    end
                    shadow_value[slot] = val;
                    shadow_prio[slot]  = prio;
                    shadow_count++;
                end
            end
            OP_DEQ: begin
                // empty dequeue leaves taken_valid low and the tag zero
                if (shadow_count > 0) begin
                    res.taken_value = shadow_value[0];
                    res.taken_valid = 1'b1;
                    for (int i = 1; i < shadow_count; i++) begin
                        shadow_value[i-1] = shadow_value[i];
                        shadow_prio[i-1]  = shadow_prio[i];
                    end
                    shadow_count--;
                end
            end
            OP_CLR: shadow_count = 0;
            default: ;  // unused code: state unchanged, status still reported
        endcase
        res.head_value    = (shadow_count != 0) ? shadow_value[0] : '0;
        res.head_priority = (shadow_count != 0) ? shadow_prio[0]  : '0;
        res.count         = COUNT_W'(shadow_count);
        res.empty_res     = (shadow_count == 0);
        if (shadow_count > peak_depth) peak_depth = shadow_count;
        pending_results.push_back(res);
    endtask

    // -------------------------------------------------------------------------
    // sender side
    // -------------------------------------------------------------------------

    // offer one item, optionally after an idle burst, and hold it until taken;
    // returns on the accepting rising edge with s_valid still high
    task automatic send_item(input op_t op, input logic [TAG_W-1:0] val,
                             input logic [PRIO_W-1:0] prio);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_value        <= val;
        s_priority_req <= prio;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_queue_op(op, val, prio);
        if (op != OP_NOP) items_sent++;
    endtask

    // priorities: half the time a small pool of whole numbers so ties are common,
    // sometimes the extremes, otherwise any 32-bit pattern
    function automatic logic [PRIO_W-1:0] pick_priority();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return PRIO_W'((int'($urandom_range(0, 6)) - 3) <<< 16);
            5:             return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default:       return $urandom;
        endcase
    endfunction

    // one random item; enq_weight steers the fill level up or down
    task automatic send_random_item(input int enq_weight);
        int  r;
        op_t op;
        r = $urandom_range(0, 99);
        if (r < 2)                   op = OP_CLR;
        else if (r < 3)              op = OP_NOP;
        else if (r < 3 + enq_weight) op = OP_ENQ;
        else                         op = OP_DEQ;
        send_item(op, $urandom, pick_priority());
    endtask

    // drop valid and wait until every predicted result has come back
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // -------------------------------------------------------------------------
    // receiver side: long hold on request, random stall bursts, else ready
    // -------------------------------------------------------------------------
    initial begin : sink_ready_gen
        int burst;
        burst = 0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_request--;
                m_ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                m_ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 5) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // -------------------------------------------------------------------------
    // result checker: each result item against the oldest prediction
    // -------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        queue_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no prediction waiting");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                check_field("taken_value",   want.taken_value,   m_taken_value);
                check_field("taken_valid",   want.taken_valid,   m_taken_valid);
                check_field("head_value",    want.head_value,    m_head_value);
                check_field("head_priority", want.head_priority, m_head_priority);
                check_field("count",         want.count,         m_count);
                check_field("empty_res",     want.empty_res,     m_empty_res);
                check_field("dropped",       want.dropped,       m_dropped);
            end
        end
    end

    // watchdog: too long without any handshake means the block hung
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // -------------------------------------------------------------------------
    // tests
    // -------------------------------------------------------------------------

    // empty-queue corner cases, priority extremes and ties, full queue,
    // dequeue order among ties, clear on a loaded queue
    task automatic test_directed();
        logic [PRIO_W-1:0] tie_prio [4];
        tie_prio = '{32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        send_item(OP_DEQ, 32'h0, 32'h0);                      // dequeue while empty
        send_item(OP_CLR, 32'h0, 32'h0);                      // clear while empty
        send_item(OP_NOP, 32'hFFFF_FFFF, 32'h7FFF_FFFF);      // unused code, junk payload
        send_item(OP_ENQ, 32'hFFFF_FFFF, 32'h0001_0000);
        send_item(OP_ENQ, 32'h0000_0000, 32'h7FFF_FFFF);      // largest priority
        send_item(OP_ENQ, 32'hA5A5_A5A5, 32'h8000_0000);      // smallest priority
        send_item(OP_ENQ, 32'h5A5A_5A5A, 32'h0000_0000);
        // the rest repeat three of those priorities plus all-ones, so ties land at both ends and mid
        for (int i = 0; i < DEPTH - 4; i++)
            send_item(OP_ENQ, 32'(i + 1), tie_prio[i % 4]);
        send_item(OP_ENQ, 32'hDEAD_BEEF, 32'h8000_0000);      // full: must be dropped
        send_item(OP_NOP, 32'h0, 32'h0);                      // unused code while loaded
        send_item(OP_DEQ, 32'h0, 32'h0);                      // ties at the minimum leave in order
        send_item(OP_DEQ, 32'h0, 32'h0);
        send_item(OP_CLR, 32'h0, 32'h0);
        send_item(OP_DEQ, 32'h0, 32'h0);
        wait_results_drained();
    endtask

    // fill past capacity, then empty past zero; the sender stops after each
    // round until every result is back
    task automatic test_fill_and_drain();
        for (int round = 0; round < 4; round++) begin
            for (int i = 0; i < DEPTH + 4; i++)
                send_item(OP_ENQ, $urandom, pick_priority());
            for (int i = 0; i < DEPTH + 2; i++)
                send_item(OP_DEQ, $urandom, pick_priority());
            wait_results_drained();
        end
    endtask

    // receiver stalls for a long stretch while items keep coming, so the
    // block backs up and has to hold s_ready low
    task automatic test_receiver_hold();
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 40; i++) send_random_item(60);
        wait_results_drained();
    endtask

    // mixed traffic with idle bursts on both sides; the fill level swings
    // between near-full and near-empty
    task automatic test_random_traffic();
        for (int i = 0; i < 350; i++)
            send_random_item(((i / 25) % 2 == 0) ? 75 : 30);
    endtask

    // back-to-back items at full rate, no idling anywhere
    task automatic test_streaming();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        for (int i = 0; i < 180; i++)
            send_random_item(((i / 20) % 2 == 0) ? 80 : 25);
    endtask

    // -------------------------------------------------------------------------
    // main sequence
    // -------------------------------------------------------------------------
    initial begin
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        hold_request = 0;
        shadow_count = 0;
        items_sent   = 0;
        results_seen = 0;
        drops_seen   = 0;
        peak_depth   = 0;
        mismatches   = 0;

        // synchronous reset, released away from the edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_fill_and_drain();
        test_receiver_hold();
        test_random_traffic();
        test_streaming();

        // let the last results out, then a short quiet tail for stray items
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d queue items, %0d refused as full, peak fill %0d of %0d",
                 items_sent, drops_seen, peak_depth, DEPTH);
        $display("%0d result items checked field by field, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_datapath.sv
hdl/sorted_priority_queue_top.sv
sim/tb_top.sv
